FILE: rtl/bpq_pkg.sv
package bpq_pkg;

  localparam int CAPACITY = 8;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 4;

  localparam logic [1:0] MODE_ENQ      = 2'd0;
  localparam logic [1:0] MODE_DEQ      = 2'd1;
  localparam logic [1:0] MODE_PEEK_MIN = 2'd2;
  localparam logic [1:0] MODE_PEEK_MAX = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } bpq_cmd_t;

  typedef struct packed {
    logic scan_last;
  } bpq_stat_t;

endpackage

FILE: rtl/bpq_ctrl.sv
module bpq_ctrl
  import bpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  bpq_stat_t stat,
  output logic      busy,
  output bpq_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/bpq_datapath.sv
module bpq_datapath
  import bpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  bpq_cmd_t                 cmd,
  output bpq_stat_t                stat,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] item_data,
  input  logic signed [DATA_W-1:0] item_priority,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] result_data,
  output logic [OCC_W-1:0]         occupancy
);

  logic signed [DATA_W-1:0] slot_data     [CAPACITY];
  logic signed [DATA_W-1:0] slot_priority [CAPACITY];
  logic [CAPACITY-1:0]      slot_valid;
  logic [CNT_W-1:0]         entry_count;

  // latched command word
  logic [1:0]               op_mode;
  logic signed [DATA_W-1:0] op_data;
  logic signed [DATA_W-1:0] op_prio;

  // scan state
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         best_idx;
  logic signed [DATA_W-1:0] best_prio;
  logic                     found;

  logic signed [DATA_W-1:0] cur_prio;
  logic                     cur_valid;
  logic                     better;
  logic                     is_enq;
  logic                     enq_ok;
  logic                     sel_ok;

  assign cur_prio       = slot_priority[idx];
  assign cur_valid      = slot_valid[idx];
  assign is_enq         = (op_mode == MODE_ENQ);
  assign stat.scan_last = (idx == IDX_W'(CAPACITY - 1));

  // strict compare keeps the lowest index on ties
  always_comb begin
    if (op_mode == MODE_PEEK_MIN) begin
      better = cur_prio < best_prio;
    end else begin
      better = cur_prio > best_prio;
    end
  end

  assign enq_ok = found && (entry_count < CNT_W'(CAPACITY));
  assign sel_ok = found && (entry_count != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode <= mode;
      op_data <= item_data;
      op_prio <= item_priority;
      idx     <= '0;
    end else if (cmd.scan) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.scan) begin
      if (is_enq) begin
        if (!cur_valid && !found) best_idx <= idx;
      end else if (cur_valid && (!found || better)) begin
        best_idx  <= idx;
        best_prio <= cur_prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.load) begin
      found <= 1'b0;
    end else if (cmd.scan) begin
      if (is_enq) begin
        if (!cur_valid) found <= 1'b1;
      end else if (cur_valid) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && is_enq && enq_ok) begin
      slot_data[best_idx]     <= op_data;
      slot_priority[best_idx] <= op_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      entry_count <= '0;
    end else if (cmd.finish) begin
      if (is_enq) begin
        if (enq_ok) begin
          slot_valid[best_idx] <= 1'b1;
          entry_count          <= entry_count + CNT_W'(1);
        end
      end else if (op_mode == MODE_DEQ && sel_ok) begin
        slot_valid[best_idx] <= 1'b0;
        entry_count          <= entry_count - CNT_W'(1);
      end
    end
  end

  // occupancy reflects the count after this operation
  logic [CNT_W-1:0] count_after;

  always_comb begin
    count_after = entry_count;
    if (is_enq) begin
      if (enq_ok) count_after = entry_count + CNT_W'(1);
    end else if (op_mode == MODE_DEQ && sel_ok) begin
      count_after = entry_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      occupancy <= OCC_W'(count_after);
      if (is_enq) begin
        status      <= enq_ok ? STAT_OK : STAT_FULL;
        result_data <= MOST_NEG;
      end else if (sel_ok) begin
        status      <= STAT_OK;
        result_data <= slot_data[best_idx];
      end else begin
        status      <= STAT_EMPTY;
        result_data <= MOST_NEG;
      end
    end
  end

endmodule

FILE: rtl/bounded_priority_queue.sv
// Each word is latched from the ports at the accepting start edge; the scan state then
// visits the slot registers one slot per cycle, the finish state updates the slots and the
// result registers, and done is registered from the finish command.
// A new word is taken only in the idle state, after the finish state; busy is high meanwhile.
// Reset (rst, synchronous): all slots marked free, count zero, controller idle.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bounded_priority_queue
  import bpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] item_data,
  input  logic signed [DATA_W-1:0] item_priority,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] result_data,
  output logic [OCC_W-1:0]         occupancy
);

  bpq_cmd_t  cmd;
  bpq_stat_t stat;

  bpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bpq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .item_data     (item_data),
    .item_priority (item_priority),
    .done          (done),
    .status        (status),
    .result_data   (result_data),
    .occupancy     (occupancy)
  );

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done)
    else $error("finish without result strobe");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_fail_data: assert property (@(posedge clk) disable iff (rst)
    done && (status == STAT_FULL || status == STAT_EMPTY) |-> result_data == MOST_NEG)
    else $error("failed operation returned data");
`endif

endmodule

FILE: test/bounded_priority_queue_tb.sv
module bounded_priority_queue_tb
  import bpq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_WORDS = 1350;
  localparam int QUIET_TAIL = 200;

  typedef struct {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] data;
    logic signed [DATA_W-1:0] prio;
    int                       gap;
    bit                       drain;
  } op_word_t;

  typedef struct {
    logic [1:0]        status;
    logic [DATA_W-1:0] data;
    logic [OCC_W-1:0]  occ;
  } bpq_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               mode = MODE_ENQ;
  logic signed [DATA_W-1:0] item_data = '0;
  logic signed [DATA_W-1:0] item_priority = '0;
  logic                     done;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] result_data;
  logic [OCC_W-1:0]         occupancy;

  // shadow copy of the queue contents
  logic signed [DATA_W-1:0] shadow_data [CAPACITY];
  logic signed [DATA_W-1:0] shadow_prio [CAPACITY];
  bit                       shadow_used [CAPACITY];
  int                       shadow_count = 0;

  op_word_t    word_q[$];
  bpq_result_t pending_results[$];
  logic        word_taken = 1'b0;
  int          total_words = 0;
  int          n_accepted = 0;
  int          n_enq = 0;
  int          n_deq = 0;
  int          n_peek = 0;
  int          n_full = 0;
  int          n_empty = 0;
  int          errors = 0;

  bounded_priority_queue DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .item_data     (item_data),
    .item_priority (item_priority),
    .done          (done),
    .status        (status),
    .result_data   (result_data),
    .occupancy     (occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lowest slot wins on equal priority, for both min and max
  function automatic bpq_result_t bpq_predict(logic [1:0] op, logic signed [DATA_W-1:0] dat,
                                              logic signed [DATA_W-1:0] pri);
    bpq_result_t r;
    int          sel;
    r.status = STAT_OK;
    r.data   = MOST_NEG;
    sel      = -1;
    if (op == MODE_ENQ) begin
      for (int i = 0; i < CAPACITY; i++)
        if (!shadow_used[i] && sel < 0) sel = i;
      if (sel < 0) begin
        r.status = STAT_FULL;
      end else begin
        shadow_data[sel] = dat;
        shadow_prio[sel] = pri;
        shadow_used[sel] = 1'b1;
        shadow_count++;
      end
    end else begin
      for (int i = 0; i < CAPACITY; i++)
        if (shadow_used[i] && (sel < 0 ||
            (op == MODE_PEEK_MIN ? shadow_prio[i] < shadow_prio[sel]
                                 : shadow_prio[i] > shadow_prio[sel])))
          sel = i;
      if (sel < 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.data = shadow_data[sel];
        if (op == MODE_DEQ) begin
          shadow_used[sel] = 1'b0;
          shadow_count--;
        end
      end
    end
    r.occ = OCC_W'(shadow_count);
    return r;
  endfunction

  task automatic add_word(logic [1:0] m, logic signed [DATA_W-1:0] d,
                          logic signed [DATA_W-1:0] p, int gap, bit drain);
    op_word_t w;
    w.mode  = m;
    w.data  = d;
    w.prio  = p;
    w.gap   = gap;
    w.drain = drain;
    word_q.push_back(w);
    total_words++;
  endtask

  // mix of extremes, a narrow band that forces ties, and full-range values
  function automatic logic signed [DATA_W-1:0] pick_value();
    int v;
    v = $urandom_range(0, 9);
    case (v)
      0:       return MOST_NEG;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return $signed($urandom_range(0, 6)) - 3;
      default: return $signed($urandom);
    endcase
  endfunction

  // driver: a word stays on the bus until start && !busy is seen at a rising edge
  op_word_t next_word;
  bit       have_next = 1'b0;
  int       gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      // hold current word
    end else begin
      if (!have_next && word_q.size() != 0) begin
        next_word = word_q.pop_front();
        have_next = 1'b1;
        gap_left  = next_word.gap;
      end
      if (have_next && gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (have_next && next_word.drain && pending_results.size() != 0) begin
        start <= 1'b0;
      end else if (have_next) begin
        start         <= 1'b1;
        mode          <= next_word.mode;
        item_data     <= next_word.data;
        item_priority <= next_word.prio;
        have_next = 1'b0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results, then record newly accepted words
  always @(posedge clk) begin
    bpq_result_t want;
    word_taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: status=%0d data=%h occ=%0d",
                   $time, status, result_data, occupancy);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            errors++;
          end
          if (result_data !== want.data) begin
            $display("%0t: result_data expected %h actual %h", $time, want.data, result_data);
            errors++;
          end
          if (occupancy !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        want = bpq_predict(mode, item_data, item_priority);
        pending_results.push_back(want);
        n_accepted++;
        if (mode == MODE_ENQ) n_enq++;
        else if (mode == MODE_DEQ) n_deq++;
        else n_peek++;
        if (want.status == STAT_FULL) n_full++;
        if (want.status == STAT_EMPTY) n_empty++;
      end
    end
  end

  initial begin
    int n_rand;
    int burst;
    int kind;
    int roll;
    bit quiet;
    logic [1:0] m;

    for (int i = 0; i < CAPACITY; i++) shadow_used[i] = 1'b0;

    // empty queue on every read operation
    add_word(MODE_DEQ, 32'sh1234_5678, 32'sh7fff_ffff, 0, 1'b0);
    add_word(MODE_PEEK_MIN, -1, MOST_NEG, 0, 1'b0);
    add_word(MODE_PEEK_MAX, 0, 0, 0, 1'b0);
    // fill with extreme priorities and ties in min and max
    add_word(MODE_ENQ, 32'sh0000_0001, MOST_NEG, 0, 1'b0);
    add_word(MODE_ENQ, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1'b0);
    add_word(MODE_ENQ, MOST_NEG, 5, 0, 1'b0);
    add_word(MODE_ENQ, -1, 32'sh7fff_ffff, 0, 1'b0);
    add_word(MODE_ENQ, 0, MOST_NEG, 0, 1'b0);
    add_word(MODE_ENQ, 32'sh5a5a_a5a5, 0, 0, 1'b0);
    add_word(MODE_ENQ, 32'sha5a5_5a5a, -1, 0, 1'b0);
    add_word(MODE_ENQ, 32'sh0f0f_f0f0, 5, 0, 1'b0);
    add_word(MODE_ENQ, 32'sh7777_7777, 32'sh7fff_ffff, 0, 1'b0);  // rejected: full
    add_word(MODE_PEEK_MIN, 0, 0, 0, 1'b0);
    add_word(MODE_PEEK_MAX, 0, 0, 0, 1'b0);
    for (int i = 0; i <= CAPACITY; i++)
      add_word(MODE_DEQ, $signed($urandom), $signed($urandom), 0, 1'b0);

    n_rand = 0;
    while (n_rand < RAND_WORDS) begin
      burst = $urandom_range(10, 40);
      kind  = $urandom_range(0, 2);
      quiet = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < burst && n_rand < RAND_WORDS; j++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0:       m = (roll < 70) ? MODE_ENQ : 2'($urandom_range(1, 3));
          1:       m = (roll < 15) ? MODE_ENQ : (roll < 70) ? MODE_DEQ : 2'($urandom_range(2, 3));
          default: m = 2'($urandom_range(0, 3));
        endcase
        add_word(m, (m == MODE_ENQ) ? pick_value() : $signed($urandom),
                 (m == MODE_ENQ) ? pick_value() : $signed($urandom),
                 (quiet || n_rand >= RAND_WORDS - QUIET_TAIL || $urandom_range(0, 2) != 0)
                   ? 0 : $urandom_range(1, 4),
                 (n_rand == 0 || n_rand == RAND_WORDS / 2));
        n_rand++;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (n_accepted < total_words) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (CAPACITY + 4) @(negedge clk);

    $display("%0d words: %0d enqueue, %0d dequeue, %0d peek", n_accepted, n_enq, n_deq, n_peek);
    $display("%0d rejected as full, %0d answered empty, %0d mismatches",
             n_full, n_empty, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/bpq_pkg.sv
rtl/bpq_ctrl.sv
rtl/bpq_datapath.sv
rtl/bounded_priority_queue.sv
test/bounded_priority_queue_tb.sv
